// ===== hdl/assert_macros.svh =====
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CHK_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");

// Antecedent at one edge forces the consequent at the next edge.
`define CHK_IMPLIES_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== hdl/rzsd_pkg.sv =====
`timescale 1ns / 1ps

package rzsd_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int PIX_W      = 8;
    localparam int LEN_W      = 11;
    localparam int BCNT_W     = 16;

    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_COMPRESSED   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             malformed;
        logic             frame_end;
        logic             row_end;
        logic [LEN_W-1:0] run_length;
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } run_beat_t;

    // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== hdl/rle_zero_sprite_row_decoder_unit.sv =====
`timescale 1ns / 1ps

// Channel   Beat accepted when         Payload
// s_*       s_tvalid && s_tready       tdata: data_byte; tuser: start_frame
// m_*       m_tvalid && m_tready       tdata: run fields; tlast: row_end;
//                                      tuser: frame_end, malformed
// cfg_*     cfg_wen at clock edge      cfg_index selects register, cfg_data value
//
// One input byte per cycle while s_tready is high, decoded in the cycle it is taken;
// each yields zero, one or two output beats, written into a 4-entry output queue.
// Output drains one beat per cycle if m_tready, so two-beat bytes run at half rate.
// s_tready is high while at least two queue slots are free, independent of m_tready.
// Reset clears decode state, registers (width 1, height 1, raw mode) and queue.

module rle_zero_sprite_row_decoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [rzsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rzsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rzsd_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] start_frame
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [9:0] row, [19:10] column, [27:20] pixel, [38:28] run_length, [39] zero
    output logic [rzsd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,   // row_end
    output logic [rzsd_pkg::M_TUSER_W-1:0]  m_tuser    // [0] frame_end, [1] malformed
);
    import rzsd_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR_LO = 2'd0,
        PH_HDR_HI = 2'd1,
        PH_BODY   = 2'd2,
        PH_COUNT  = 2'd3
    } phase_t;

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic              compressed_reg;

    phase_t            phase_reg, phase_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [BCNT_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0]  clb_reg, clb_next;
    logic              fc_reg, fc_next;

    run_beat_t         q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    logic [DIM_W-1:0]  w, h;
    logic [PIX_W-1:0]  b;
    logic              s_acc, m_acc;
    logic              prim_v, tail_v, tail_mal, last_row, row_done;
    run_beat_t         prim, tail, beat0;
    logic [1:0]        n_push;
    logic [BCNT_W-1:0] size, left_dec;
    logic [DIM_W-1:0]  avail, run;

    assign b     = s_tdata;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign w     = eff_dim(width_reg);
    assign h     = eff_dim(height_reg);

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        left_next  = left_reg;
        clb_next   = clb_reg;
        fc_next    = fc_reg;
        prim_v     = 1'b0;
        prim       = '0;
        tail_v     = 1'b0;
        tail_mal   = 1'b0;
        tail       = '0;
        row_done   = 1'b0;
        size       = {b, clb_reg};
        avail      = '0;
        run        = '0;

        if (s_tuser)
        begin
            phase_next = PH_HDR_LO;
            row_next   = '0;
            col_next   = '0;
            left_next  = '0;
            fc_next    = 1'b0;
        end
        left_dec = left_next - BCNT_W'(1);
        last_row = ({1'b0, row_next} + DIM_W'(1)) >= h;

        if (!fc_next)
        begin
            if (!compressed_reg)
            begin
                prim_v    = 1'b1;
                prim.row  = row_next;
                prim.pixel = b;
                if (col_next < w)
                begin
                    prim.column     = col_next[COL_W-1:0];
                    prim.run_length = LEN_W'(1);
                    col_next        = col_next + DIM_W'(1);
                    row_done        = (col_next >= w);
                end
                else
                begin
                    prim.malformed = 1'b1;
                    row_done       = 1'b1;
                end
                prim.row_end   = row_done;
                prim.frame_end = row_done && last_row;
            end
            else
            begin
                case (phase_next)
                    PH_HDR_LO:
                    begin
                        clb_next   = b;
                        phase_next = PH_HDR_HI;
                    end
                    PH_HDR_HI:
                    begin
                        if (size <= BCNT_W'(2))
                        begin
                            tail_v   = 1'b1;
                            tail_mal = (size < BCNT_W'(2));
                        end
                        else
                        begin
                            left_next  = size - BCNT_W'(2);
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        left_next = left_dec;
                        if (b != '0)
                        begin
                            prim_v     = 1'b1;
                            prim.row   = row_next;
                            prim.pixel = b;
                            if (col_next < w)
                            begin
                                prim.column     = col_next[COL_W-1:0];
                                prim.run_length = LEN_W'(1);
                                col_next        = col_next + DIM_W'(1);
                            end
                            else
                                prim.malformed = 1'b1;
                            tail_v = (left_dec == '0);
                        end
                        else if (left_dec == '0)
                        begin
                            tail_v   = 1'b1;
                            tail_mal = 1'b1;
                        end
                        else
                            phase_next = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        avail = (col_next < w) ? (w - col_next) : '0;
                        run   = (DIM_W'(b) < avail) ? DIM_W'(b) : avail;
                        prim_v          = 1'b1;
                        prim.row        = row_next;
                        prim.column     = (run == '0) ? '0 : col_next[COL_W-1:0];
                        prim.run_length = run;
                        prim.malformed  = (DIM_W'(b) > avail);
                        col_next        = col_next + run;
                        left_next       = left_dec;
                        phase_next      = PH_BODY;
                        tail_v          = (left_dec == '0);
                    end
                    default:
                        phase_next = PH_HDR_LO;
                endcase

                if (tail_v)
                begin
                    tail.row        = row_next;
                    tail.column     = (col_next < w) ? col_next[COL_W-1:0] : '0;
                    tail.run_length = (col_next < w) ? (w - col_next) : '0;
                    tail.row_end    = 1'b1;
                    tail.frame_end  = last_row;
                    tail.malformed  = tail_mal;
                    row_done        = 1'b1;
                end
            end

            if (row_done)
            begin
                col_next   = '0;
                phase_next = PH_HDR_LO;
                left_next  = '0;
                if (last_row)
                    fc_next = 1'b1;
                else
                    row_next = row_next + ROW_W'(1);
            end
        end
    end

    assign beat0  = prim_v ? prim : tail;
    assign n_push = s_acc ? ({1'b0, prim_v} + {1'b0, tail_v}) : 2'd0;

    assign wr_ptr_next = wr_ptr_reg + Q_PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + Q_PTR_W'(m_acc);
    assign cnt_next    = cnt_reg + Q_CNT_W'(n_push) - Q_CNT_W'(m_acc);

    assign s_tready = (cnt_reg < Q_CNT_W'(Q_DEPTH - 1));
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {1'b0, q_mem_reg[rd_ptr_reg].run_length, q_mem_reg[rd_ptr_reg].pixel,
                       q_mem_reg[rd_ptr_reg].column, q_mem_reg[rd_ptr_reg].row};
    assign m_tlast  = q_mem_reg[rd_ptr_reg].row_end;
    assign m_tuser  = {q_mem_reg[rd_ptr_reg].malformed, q_mem_reg[rd_ptr_reg].frame_end};

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_mem_reg[wr_ptr_reg] <= beat0;
        if (n_push == 2'd2)
            q_mem_reg[wr_ptr_reg + Q_PTR_W'(1)] <= tail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= DIM_W'(1);
            height_reg     <= DIM_W'(1);
            compressed_reg <= 1'b0;
            phase_reg      <= PH_HDR_LO;
            row_reg        <= '0;
            col_reg        <= '0;
            left_reg       <= '0;
            clb_reg        <= '0;
            fc_reg         <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg      <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg     <= cfg_data;
                    REG_COMPRESSED:   compressed_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (s_acc)
            begin
                phase_reg <= phase_next;
                row_reg   <= row_next;
                col_reg   <= col_next;
                left_reg  <= left_next;
                clb_reg   <= clb_next;
                fc_reg    <= fc_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hdl/rzsd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rzsd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_wen,
    input logic [rzsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [rzsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rzsd_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rzsd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast,
    input logic [rzsd_pkg::M_TUSER_W-1:0]  m_tuser
);
    import rzsd_pkg::*;

    logic [DIM_W:0] run_end;
    logic           unused_in;

    assign run_end   = (DIM_W+1)'(m_tdata[19:10]) + (DIM_W+1)'(m_tdata[38:28]);
    assign unused_in = cfg_wen ^ (^cfg_index) ^ (^cfg_data) ^ s_tvalid ^ s_tready
                       ^ (^s_tdata) ^ s_tuser;

    // frame end only ever rides on the beat that closes a row
    `CHK_ALWAYS(a_fend_on_row_end, !(m_tvalid && m_tuser[0] && !m_tlast))

    // clipping keeps every run inside the row; the check bounds its end by MAX_DIM
    `CHK_ALWAYS(a_run_in_row, !m_tvalid || (run_end <= (DIM_W+1)'(MAX_DIM)))

    // colored runs cover at most one pixel
    `CHK_ALWAYS(a_pixel_single, !m_tvalid || (m_tdata[27:20] == '0) || (m_tdata[38:28] <= 11'd1))

    `CHK_IMPLIES_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind rle_zero_sprite_row_decoder_unit rzsd_checker u_rzsd_checker (.*);
